### hdl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the sextet-to-character mapping for the
// streaming Base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int BYTE_W  = 8;
  localparam int CHAR_W  = 7;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 7'd61;   // '='

  // number of message bytes carried by a group
  typedef enum logic [1:0] {
    GRP_ONE   = 2'd1,
    GRP_TWO   = 2'd2,
    GRP_THREE = 2'd3
  } grp_len_t;

  // one complete or final group handed from front to back
  typedef struct packed {
    logic [BYTE_W-1:0] byte_a;
    logic [BYTE_W-1:0] byte_b;
    logic [BYTE_W-1:0] byte_c;
    grp_len_t          len;
    logic              last;
  } group_t;

  function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] v);
    logic [CHAR_W-1:0] v7;
    logic [CHAR_W-1:0] ch;
    v7 = {1'b0, v};
    if (v < 6'd26) begin
      ch = v7 + 7'd65;          // 'A'..'Z'
    end else if (v < 6'd52) begin
      ch = v7 + 7'd71;          // 'a'..'z'
    end else if (v < 6'd62) begin
      ch = v7 - 7'd4;           // '0'..'9'
    end else if (v == 6'd62) begin
      ch = 7'd43;               // '+'
    end else begin
      ch = 7'd47;               // '/'
    end
    return ch;
  endfunction

endpackage

### hdl/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming Base64 encoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
// Input channel: one message byte per transaction on in_tdata, in_tlast set on
// the final byte of a message. Output channel: one quartet of ASCII characters
// per transaction, out_tlast set on the quartet that closes the message.
// Every third byte of a group yields a quartet; a final byte that leaves one
// or two bytes over yields a quartet padded with "==" or "=".
// Throughput is one byte per clock: the collector accepts a byte every cycle
// while the two-entry group queue has room.
// The byte that completes a group, or the final byte, writes the group into
// the queue when it is accepted; the output register loads the queue head
// while it is empty or out_tready is high, and out_tvalid shows the quartet.
// Reset empties the open group, the queue and the output register.
// While the receiver holds out_tready low, the quartet stays in the output
// register, the queue fills and in_tready drops once both entries are taken.
// ----------------------------------------------------------------------------
module base64_stream_encoder
  import b64e_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [6:0] char_first, [13:7] char_second,
                                  // [20:14] char_third, [27:21] char_fourth
  output logic        out_tlast   // message_end
);

  logic   q_full;
  logic   q_push;
  logic   q_pop;
  logic   q_not_empty;
  group_t q_in;
  group_t q_head;

  b64e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_group   (q_in)
  );

  b64e_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_group (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  b64e_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

### hdl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Accepts message bytes, collects them into three-byte groups and pushes a
// group into the queue when it completes or the final byte arrives.
// ----------------------------------------------------------------------------
module b64e_front
  import b64e_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_last,
  input  logic              q_full,
  output logic              q_push,
  output group_t            q_group
);

  logic [BYTE_W-1:0] held_a_r, held_a_nxt;
  logic [BYTE_W-1:0] held_b_r, held_b_nxt;
  logic [1:0]        fill_r, fill_nxt;
  logic              accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    held_a_nxt     = held_a_r;
    held_b_nxt     = held_b_r;
    fill_nxt       = fill_r;
    q_push         = 1'b0;
    q_group.byte_a = held_a_r;
    q_group.byte_b = held_b_r;
    q_group.byte_c = in_byte;
    q_group.len    = GRP_THREE;
    q_group.last   = in_last;
    case (fill_r)
      2'd1: begin
        q_group.byte_b = in_byte;
        q_group.byte_c = '0;
        q_group.len    = GRP_TWO;
        if (accept) begin
          if (in_last) begin
            q_push   = 1'b1;
            fill_nxt = 2'd0;
          end else begin
            held_b_nxt = in_byte;
            fill_nxt   = 2'd2;
          end
        end
      end
      2'd2: begin
        if (accept) begin
          q_push   = 1'b1;
          fill_nxt = 2'd0;
        end
      end
      default: begin
        // empty group (a stray fill of three reads as empty too)
        q_group.byte_a = in_byte;
        q_group.byte_b = '0;
        q_group.byte_c = '0;
        q_group.len    = GRP_ONE;
        if (accept) begin
          if (in_last) begin
            q_push   = 1'b1;
            fill_nxt = 2'd0;
          end else begin
            held_a_nxt = in_byte;
            fill_nxt   = 2'd1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_a_r <= held_a_nxt;
    held_b_r <= held_b_nxt;
  end

endmodule

### hdl/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Two-entry group queue decoupling the byte collector from the encoder.
// ----------------------------------------------------------------------------
module b64e_queue
  import b64e_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  group_t push_group,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output group_t head
);

  group_t            entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_group;
    end
  end

endmodule

### hdl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Takes groups from the queue, maps them to four Base64 characters with
// padding and holds the quartet in the output register.
// ----------------------------------------------------------------------------
module b64e_back
  import b64e_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_not_empty,
  input  group_t      q_head,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic        out_tlast
);

  logic              valid_r, valid_nxt;
  logic [4*CHAR_W-1:0] chars_r, chars_nxt;
  logic              last_r, last_nxt;
  logic [CHAR_W-1:0] c0, c1, c2, c3;

  assign q_pop = q_not_empty && (!valid_r || out_tready);

  always_comb begin
    c0 = sextet_char(q_head.byte_a[7:2]);
    c1 = sextet_char({q_head.byte_a[1:0], q_head.byte_b[7:4]});
    c2 = sextet_char({q_head.byte_b[3:0], q_head.byte_c[7:6]});
    c3 = sextet_char(q_head.byte_c[5:0]);
    case (q_head.len)
      GRP_ONE: begin
        c2 = PAD_CHAR;
        c3 = PAD_CHAR;
      end
      GRP_TWO: begin
        c3 = PAD_CHAR;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    chars_nxt = chars_r;
    last_nxt  = last_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
      chars_nxt = {c3, c2, c1, c0};
      last_nxt  = q_head.last;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chars_r <= chars_nxt;
    last_r  <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {4'b0000, chars_r};
  assign out_tlast  = last_r;

endmodule
